@@ design/ms_pkg.sv @@
// Shared constants and types for the merge sorter core.
`default_nettype none

package ms_pkg;

	localparam int CAPACITY = 32;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// One write port and two read ports of a storage bank.
	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		addr_t raddr_a;
		addr_t raddr_b;
	} ms_bank_req_t;

endpackage

`default_nettype wire

@@ design/ms_bank.sv @@
// Storage bank: one write port, two registered read ports.
`default_nettype none

module ms_bank (
	input  wire                 clk,
	input  wire ms_pkg::ms_bank_req_t req,
	output ms_pkg::word_t       rdata_a,
	output ms_pkg::word_t       rdata_b
);
	import ms_pkg::*;

	word_t mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_a <= mem_q[req.raddr_a];
		rdata_b <= mem_q[req.raddr_b];
	end

endmodule

`default_nettype wire

@@ design/merge_sorter_core.sv @@
// Top level of the merge sorter: load, bottom-up merge passes and run output.
`default_nettype none

// Collects signed 32-bit values, one request per cycle on the slave side, into
// bank 0. The request with s_tlast high closes the set; the set is then sorted
// ascending (stable: on equal keys the left run goes first) and sent out on
// the master side with m_tlast on the final element and m_tuser set on every
// element if requests beyond the 32-entry capacity were dropped. A dropped
// request that carries tlast still closes the set. Sorting runs ceil(log2 n)
// merge passes that ping-pong between two banks; each merged element takes a
// bank read, then a compare and write back. Each output element is likewise
// read from the bank, then presented. No new request is taken until the run
// has been fully delivered.
module merge_sorter_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [31:0]         s_tdata,   // [31:0] value
	input  wire                 s_tlast,   // last element of the set
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [31:0]         m_tdata,   // [31:0] sorted_value
	output logic                m_tlast,   // end_of_run
	output logic [0:0]          m_tuser    // [0] overflow
);
	import ms_pkg::*;

	localparam logic [2:0] ST_LOAD     = 3'd0;
	localparam logic [2:0] ST_READ     = 3'd1;
	localparam logic [2:0] ST_MERGE    = 3'd2;
	localparam logic [2:0] ST_OUT_RD   = 3'd3;
	localparam logic [2:0] ST_OUT_SHOW = 3'd4;

	typedef struct packed {
		cnt_t mid;
		cnt_t hi;
	} seg_t;

	// Bounds of the run pair that starts at lo: mid = min(lo+w, n), hi = min(lo+2w, n).
	function automatic seg_t seg_bounds(cnt_t lo, cnt_t w, cnt_t n);
		logic [CNT_W:0] sum1;
		logic [CNT_W:0] sum2;
		seg_t           s;
		sum1  = {1'b0, lo} + {1'b0, w};
		sum2  = sum1 + {1'b0, w};
		s.mid = (sum1 > {1'b0, n}) ? n : sum1[CNT_W-1:0];
		s.hi  = (sum2 > {1'b0, n}) ? n : sum2[CNT_W-1:0];
		return s;
	endfunction

	logic [2:0] state_q, state_d;
	cnt_t       count_q, count_d;
	logic       dropped_q, dropped_d;
	logic       src_sel_q, src_sel_d;   // bank holding the source runs
	cnt_t       width_q, width_d;
	cnt_t       mid_q, mid_d;
	cnt_t       hi_q, hi_d;
	cnt_t       i_q, i_d;
	cnt_t       j_q, j_d;
	cnt_t       k_q, k_d;

	ms_bank_req_t bank0_req, bank1_req;
	word_t        b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
	word_t        src_a, src_b;
	logic         take_a;
	word_t        merged;
	cnt_t         width_nxt;
	cnt_t         count_inc;
	seg_t         seg;
	logic         s_accept, m_accept;

	ms_bank u_bank0 (
		.clk     (clk),
		.req     (bank0_req),
		.rdata_a (b0_rd_a),
		.rdata_b (b0_rd_b)
	);

	ms_bank u_bank1 (
		.clk     (clk),
		.req     (bank1_req),
		.rdata_a (b1_rd_a),
		.rdata_b (b1_rd_b)
	);

	assign src_a  = src_sel_q ? b1_rd_a : b0_rd_a;
	assign src_b  = src_sel_q ? b1_rd_b : b0_rd_b;

	// Take the left head while the left run lasts and the right run is used up or its head is not smaller.
	assign take_a = (i_q < mid_q) &&
		((j_q >= hi_q) || ($signed(src_a) <= $signed(src_b)));
	assign merged = take_a ? src_a : src_b;

	assign width_nxt = {width_q[CNT_W-2:0], 1'b0};
	assign count_inc = count_q + cnt_t'(1);

	assign s_tready = (state_q == ST_LOAD);
	assign s_accept = s_tvalid && s_tready;

	assign m_tvalid = (state_q == ST_OUT_SHOW);
	assign m_tdata  = src_a;
	assign m_tlast  = (i_q + cnt_t'(1) == count_q);
	assign m_tuser  = dropped_q;
	assign m_accept = m_tvalid && m_tready;

	// Bank ports: both banks read the run heads; load writes bank 0, merge writes the other bank.
	always_comb begin
		bank0_req         = '0;
		bank1_req         = '0;
		bank0_req.raddr_a = i_q[ADDR_W-1:0];
		bank0_req.raddr_b = j_q[ADDR_W-1:0];
		bank1_req.raddr_a = i_q[ADDR_W-1:0];
		bank1_req.raddr_b = j_q[ADDR_W-1:0];
		if (s_accept && (count_q < cnt_t'(CAPACITY))) begin
			bank0_req.we    = 1'b1;
			bank0_req.waddr = count_q[ADDR_W-1:0];
			bank0_req.wdata = s_tdata;
		end
		if (state_q == ST_MERGE) begin
			if (src_sel_q) begin
				bank0_req.we    = 1'b1;
				bank0_req.waddr = k_q[ADDR_W-1:0];
				bank0_req.wdata = merged;
			end else begin
				bank1_req.we    = 1'b1;
				bank1_req.waddr = k_q[ADDR_W-1:0];
				bank1_req.wdata = merged;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		dropped_d = dropped_q;
		src_sel_d = src_sel_q;
		width_d   = width_q;
		mid_d     = mid_q;
		hi_d      = hi_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		seg       = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (s_accept) begin
					// Store while room is left, otherwise drop and flag.
					if (count_q < cnt_t'(CAPACITY)) begin
						count_d = count_inc;
					end else begin
						dropped_d = 1'b1;
					end
					if (s_tlast) begin
						src_sel_d = 1'b0;
						width_d   = cnt_t'(1);
						if (count_d <= cnt_t'(1)) begin
							i_d     = '0;
							state_d = ST_OUT_RD;
						end else begin
							seg     = seg_bounds('0, cnt_t'(1), count_d);
							mid_d   = seg.mid;
							hi_d    = seg.hi;
							i_d     = '0;
							j_d     = seg.mid;
							k_d     = '0;
							state_d = ST_READ;
						end
					end
				end
			end
			ST_READ: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				state_d = ST_READ;
				if (take_a) begin
					i_d = i_q + cnt_t'(1);
				end else begin
					j_d = j_q + cnt_t'(1);
				end
				k_d = k_q + cnt_t'(1);
				if (k_q + cnt_t'(1) == hi_q) begin
					if (hi_q == count_q) begin
						// Pass done: swap banks, double the run width.
						src_sel_d = !src_sel_q;
						width_d   = width_nxt;
						if (width_nxt >= count_q) begin
							i_d     = '0;
							state_d = ST_OUT_RD;
						end else begin
							seg   = seg_bounds('0, width_nxt, count_q);
							mid_d = seg.mid;
							hi_d  = seg.hi;
							i_d   = '0;
							j_d   = seg.mid;
							k_d   = '0;
						end
					end else begin
						// Advance to the next pair of runs in this pass.
						seg   = seg_bounds(hi_q, width_q, count_q);
						mid_d = seg.mid;
						hi_d  = seg.hi;
						i_d   = hi_q;
						j_d   = seg.mid;
						k_d   = hi_q;
					end
				end
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_SHOW;
			end
			ST_OUT_SHOW: begin
				// Hold the read address and data until the request is taken.
				if (m_accept) begin
					if (i_q + cnt_t'(1) == count_q) begin
						count_d   = '0;
						dropped_d = 1'b0;
						state_d   = ST_LOAD;
					end else begin
						i_d     = i_q + cnt_t'(1);
						state_d = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			src_sel_q <= 1'b0;
			width_q   <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			dropped_q <= dropped_d;
			src_sel_q <= src_sel_d;
			width_q   <= width_d;
			mid_q     <= mid_d;
			hi_q      <= hi_d;
			i_q       <= i_d;
			j_q       <= j_d;
			k_q       <= k_d;
		end
	end

endmodule

`default_nettype wire

@@ test/tb_merge_sorter_core.sv @@
// Self-checking testbench for merge_sorter_core: random sets, stalls on both sides.
`default_nettype none

module tb_merge_sorter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ms_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 460;

	// one request on the slave side; hold makes the driver wait for an empty scoreboard
	typedef struct {
		word_t value;
		bit    last;
		bit    hold;
	} load_req_t;

	// one element of a sorted run
	typedef struct {
		word_t value;
		bit    end_of_run;
		bit    overflow;
	} sorted_elem_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;    // [31:0] value
	logic        s_tlast = 1'b0;  // last element of the set
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] sorted_value
	logic        m_tlast;         // end_of_run
	logic [0:0]  m_tuser;         // [0] overflow

	load_req_t    load_q[$];      // requests still to be driven
	sorted_elem_t sorted_q[$];    // sorted elements still to come out
	int           set_vals[$];    // elements of the set being loaded
	bit           set_dropped;    // an element of this set was lost to capacity
	load_req_t    cur_req;
	int           send_gap;
	int           recv_stall;
	bit           calm;
	int           errors;
	int           cycles;

	merge_sorter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones; calm stretches run with no gaps at all.
	function automatic int draw_gap();
		int r;
		if ($urandom_range(0, 63) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Track one accepted request; on last, sort the set and queue the run.
	task automatic absorb_request(word_t v, bit l);
		int           vals[$];
		int           key;
		int           j;
		sorted_elem_t r;
		if (set_vals.size() < CAPACITY)
			set_vals.push_back(int'(v));
		else
			set_dropped = 1'b1;
		if (!l)
			return;
		vals = set_vals;
		// stable insertion sort, ascending on signed keys
		for (int i = 1; i < vals.size(); i++) begin
			key = vals[i];
			j = i - 1;
			while (j >= 0 && vals[j] > key) begin
				vals[j + 1] = vals[j];
				j--;
			end
			vals[j + 1] = key;
		end
		for (int i = 0; i < vals.size(); i++) begin
			r.value = word_t'(vals[i]);
			r.end_of_run = (i == vals.size() - 1);
			r.overflow = set_dropped;
			sorted_q.push_back(r);
		end
		set_vals.delete();
		set_dropped = 1'b0;
	endtask

	// Compare one delivered element with the oldest expected one.
	task automatic check_result();
		sorted_elem_t want;
		if (sorted_q.size() == 0) begin
			$display("%0t: unexpected result data=%h last=%b user=%b",
				$time, m_tdata, m_tlast, m_tuser);
			errors++;
		end else begin
			want = sorted_q.pop_front();
			if (m_tdata !== want.value) begin
				$display("%0t: sorted_value expected %h actual %h",
					$time, want.value, m_tdata);
				errors++;
			end
			if (m_tlast !== want.end_of_run) begin
				$display("%0t: end_of_run expected %b actual %b",
					$time, want.end_of_run, m_tlast);
				errors++;
			end
			if (m_tuser[0] !== want.overflow) begin
				$display("%0t: overflow expected %b actual %b",
					$time, want.overflow, m_tuser[0]);
				errors++;
			end
		end
	endtask

	// Driver: predict on each accepted request, then present the next one or idle.
	// s_tvalid gets at most one nonblocking assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_request(cur_req.value, cur_req.last);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (load_q.size() > 0 &&
						!(load_q[0].hold && sorted_q.size() > 0)) begin
					cur_req = load_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_req.value;
					s_tlast <= cur_req.last;
					send_gap = draw_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each delivered element, stall tready at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_stall = draw_gap();
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL merge_sorter_core");
			$finish;
		end
	end

	task automatic push_req(word_t v, bit l, bit h);
		load_req_t q;
		q.value = v;
		q.last = l;
		q.hold = h;
		load_q.push_back(q);
	endtask

	// Mix of full-range words, extremes and a narrow band that forces duplicates.
	function automatic word_t pick_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			1, 2, 3: return word_t'($urandom_range(0, 7) - 4);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_random_set(int n, bit h);
		for (int k = 0; k < n; k++)
			push_req(pick_value(), k == n - 1, h && k == 0);
	endtask

	initial begin
		int n;
		int r;
		errors = 0;
		cycles = 0;
		send_gap = 0;
		recv_stall = 0;
		calm = 1'b0;
		set_dropped = 1'b0;

		// directed: one-element set
		push_req(32'd5, 1'b1, 1'b0);
		// key extremes, including the largest key twice
		push_req(32'h7fff_ffff, 1'b0, 1'b0);
		push_req(32'h8000_0000, 1'b0, 1'b0);
		push_req(32'h0000_0000, 1'b0, 1'b0);
		push_req(32'hffff_ffff, 1'b0, 1'b0);
		push_req(32'h0000_0001, 1'b0, 1'b0);
		push_req(32'h7fff_ffff, 1'b1, 1'b0);
		// equal keys
		push_req(32'd7, 1'b0, 1'b1);
		push_req(-32'sd3, 1'b0, 1'b0);
		push_req(32'd7, 1'b0, 1'b0);
		push_req(-32'sd3, 1'b0, 1'b0);
		push_req(32'd0, 1'b1, 1'b0);
		// descending input, then a two-element set already in order
		push_req(32'd3, 1'b0, 1'b0);
		push_req(32'd2, 1'b0, 1'b0);
		push_req(32'd1, 1'b1, 1'b0);
		push_req(32'h8000_0000, 1'b0, 1'b0);
		push_req(32'h7fff_ffff, 1'b1, 1'b0);

		// store exactly full, one past full (the dropped element closes the set),
		// and well past full
		add_random_set(CAPACITY, 1'b1);
		add_random_set(CAPACITY + 1, 1'b0);
		add_random_set(CAPACITY + 13, 1'b1);

		// random sets, mostly small
		while (load_q.size() < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				n = $urandom_range(1, 8);
			else if (r < 95)
				n = $urandom_range(9, CAPACITY - 1);
			else
				n = $urandom_range(CAPACITY, CAPACITY + 8);
			add_random_set(n, $urandom_range(0, 9) == 0);
		end

		// hold reset, then release it away from the rising edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all requests to go in, then for every run to come out
		while (load_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && sorted_q.size() == 0) begin
			$display("PASS merge_sorter_core");
		end else begin
			$display("FAIL merge_sorter_core");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
design/ms_pkg.sv
design/ms_bank.sv
design/merge_sorter_core.sv
test/tb_merge_sorter_core.sv
